/* sv/dmc_pkg.sv */
// Shared types, codes, constants and the rate table of the delta-modulation sample channel.
package dmc_pkg;

  // Item commands
  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_FETCH   = 3'd1,
    CMD_ENABLE  = 3'd2,
    CMD_LOAD    = 3'd3,
    CMD_CLR_IRQ = 3'd4
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_IRQ_EN = 3'd0,
    REG_LOOP   = 3'd1,
    REG_RATE   = 3'd2,
    REG_ADDR   = 3'd3,
    REG_LEN    = 3'd4
  } reg_e;

  localparam logic [15:0] AddrBase    = 16'hC000;
  localparam logic [15:0] AddrTop     = 16'hFFFF;
  localparam logic [15:0] AddrWrap    = 16'h8000;
  localparam logic [6:0]  LevelMax    = 7'd127;
  localparam logic [6:0]  LevelStep   = 7'd2;
  localparam logic [3:0]  BitsPerByte = 4'd8;

  typedef struct packed {
    logic [2:0]  command;
    logic        enable_flag;
    logic [7:0]  data_value;
    logic [15:0] fetch_address;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  output_level;
    logic        irq_pending;
    logic        bytes_remaining;
    logic        fetch_request;
    logic [15:0] fetch_request_address;
    logic        fetch_from_output;
  } out_item_t;

  typedef struct packed {
    logic [2:0] index;
    logic [7:0] value;
  } cfg_item_t;

  // Divider reload value: output bit period minus one
  function automatic logic [7:0] rate_reload(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = 8'd213;
      4'd1:    r = 8'd189;
      4'd2:    r = 8'd169;
      4'd3:    r = 8'd159;
      4'd4:    r = 8'd142;
      4'd5:    r = 8'd126;
      4'd6:    r = 8'd112;
      4'd7:    r = 8'd106;
      4'd8:    r = 8'd94;
      4'd9:    r = 8'd79;
      4'd10:   r = 8'd70;
      4'd11:   r = 8'd63;
      4'd12:   r = 8'd52;
      4'd13:   r = 8'd41;
      4'd14:   r = 8'd35;
      default: r = 8'd26;
    endcase
    return r;
  endfunction

endpackage

/* sv/dmc_stream_if.sv */
// Valid/ready channel carrying one payload item of a chosen type.
interface dmc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/delta_modulation_sample_channel.sv */
// Delta-modulation sample channel: input register, channel update, result register.
// An accepted item waits in the input register, then its result is loaded into the result
// register and shown on out_o; a result still waiting in the result register holds it back.
// Throughput: one item per cycle while out_o is taken; the single pass through
// the channel update between the input and result registers sets that figure.
// Reset (rst_ni low, asynchronous): both registers empty, channel silent with
// level 0, bit counter 8, buffer empty, no bytes left, configuration cleared.
module delta_modulation_sample_channel (
  input  logic          clk_i,
  input  logic          rst_ni,
  dmc_stream_if.sink    in_i,
  dmc_stream_if.sink    cfg_i,
  dmc_stream_if.source  out_o
);

  // Input register: holds the accepted item until the channel update takes it.
  logic               in_valid_q;
  dmc_pkg::in_item_t  in_item_q;

  // Result register: holds the finished item until the sink takes it.
  logic               out_valid_q;
  dmc_pkg::out_item_t out_item_q;

  dmc_pkg::out_item_t result;
  dmc_pkg::cfg_item_t cfg_item;
  logic               advance;
  logic               in_accept;
  logic               cfg_we;

  // Advance the held item when the result register is empty or drains now.
  assign advance   = in_valid_q && (!out_valid_q || out_o.ready);
  // Take a new item whenever the input register frees up this cycle.
  assign in_i.ready = !in_valid_q || advance;
  assign in_accept = in_i.valid && in_i.ready;

  // Configuration is to be written only while idle; the block does not enforce it, so always accept it.
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign cfg_item    = cfg_i.data;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // Payload needs no reset; load only on accept so a waiting item holds.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  // The channel state steps exactly once for each item that advances.
  dmc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .cfg_we_i (cfg_we),
    .cfg_i    (cfg_item),
    .result_o (result)
  );

  // A result without a fetch carries a clean address and origin.
  a_req_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_item_q.fetch_request
      |-> out_item_q.fetch_request_address == '0 && !out_item_q.fetch_from_output)
    else $error("fetch fields set without a fetch request");

  // An accepted item that cannot advance at once stays held.
  a_in_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_item_q))
    else $error("held item lost or changed");

  // Every advanced item lands in the result register.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced item did not reach the result register");

  // A result waiting on the sink is not overwritten.
  a_out_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_item_q))
    else $error("waiting result lost or changed");

endmodule

/* sv/dmc_core.sv */
// Channel state, configuration registers and the per-item update logic.
module dmc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  dmc_pkg::in_item_t   item_i,
  input  logic                cfg_we_i,
  input  dmc_pkg::cfg_item_t  cfg_i,
  output dmc_pkg::out_item_t  result_o
);

  // configuration
  logic        irq_en_q, loop_q;
  logic [7:0]  reload_q, addr_code_q, len_code_q;

  // channel state
  logic [6:0]  level_q, level_d;
  logic [7:0]  sr_q, sr_d;
  logic [3:0]  br_q, br_d, br_dec;
  logic        silent_q, silent_d;
  logic [7:0]  buf_q, buf_d;
  logic        empty_q, empty_d;
  logic [15:0] addr_q, addr_d;
  logic [11:0] bl_q, bl_d, bl_dec;
  logic        irq_q, irq_d;
  logic [7:0]  div_q, div_d;

  logic [15:0] restart_addr;
  logic [11:0] restart_len;
  logic        req;
  logic        from_out;
  logic [15:0] req_addr;

  assign restart_addr = dmc_pkg::AddrBase + 16'({addr_code_q, 6'b0});
  assign restart_len  = 12'({len_code_q, 4'b0}) + 12'd1;
  assign bl_dec       = bl_q - 12'd1;

  always_comb begin
    level_d  = level_q;
    sr_d     = sr_q;
    br_d     = br_q;
    br_dec   = br_q - 4'd1;
    silent_d = silent_q;
    buf_d    = buf_q;
    empty_d  = empty_q;
    addr_d   = addr_q;
    bl_d     = bl_q;
    irq_d    = irq_q;
    div_d    = div_q;
    req      = 1'b0;
    from_out = 1'b0;
    req_addr = '0;
    if (step_i) begin
      unique case (item_i.command)
        dmc_pkg::CMD_TICK: begin
          if (div_q == '0) begin
            div_d = reload_q;
            if (!silent_q) begin
              if (sr_q[0]) begin
                if (level_q <= dmc_pkg::LevelMax - dmc_pkg::LevelStep) begin
                  level_d = level_q + dmc_pkg::LevelStep;
                end
              end else if (level_q >= dmc_pkg::LevelStep) begin
                level_d = level_q - dmc_pkg::LevelStep;
              end
            end
            sr_d = sr_q >> 1;
            br_d = br_dec;
            if (br_dec == '0) begin
              br_d = dmc_pkg::BitsPerByte;
              if (empty_q) begin
                silent_d = 1'b1;
              end else begin
                silent_d = 1'b0;
                sr_d     = buf_q;
                empty_d  = 1'b1;
                if (bl_q != '0) begin
                  req      = 1'b1;
                  from_out = 1'b1;
                  req_addr = addr_q;
                end
              end
            end
          end else begin
            div_d = div_q - 8'd1;
          end
        end
        dmc_pkg::CMD_FETCH: begin
          if (item_i.fetch_address == addr_q && bl_q != '0) begin
            buf_d   = item_i.data_value;
            empty_d = 1'b0;
            addr_d  = (addr_q == dmc_pkg::AddrTop) ? dmc_pkg::AddrWrap : addr_q + 16'd1;
            bl_d    = bl_dec;
            if (bl_dec == '0) begin
              if (loop_q) begin
                addr_d = restart_addr;
                bl_d   = restart_len;
              end else if (irq_en_q) begin
                irq_d = 1'b1;
              end
            end
          end
        end
        dmc_pkg::CMD_ENABLE: begin
          if (!item_i.enable_flag) begin
            bl_d = '0;
          end else if (bl_q == '0) begin
            addr_d = restart_addr;
            bl_d   = restart_len;
            // restart length is never zero
            if (empty_q) begin
              req      = 1'b1;
              req_addr = restart_addr;
            end
          end
        end
        dmc_pkg::CMD_LOAD:    level_d = item_i.data_value[6:0];
        dmc_pkg::CMD_CLR_IRQ: irq_d   = 1'b0;
        default: ;
      endcase
    end
    // disabling the interrupt drops a pending one
    if (cfg_we_i && cfg_i.index == dmc_pkg::REG_IRQ_EN && !cfg_i.value[0]) begin
      irq_d = 1'b0;
    end
  end

  always_comb begin
    result_o.output_level          = level_d;
    result_o.irq_pending           = irq_d;
    result_o.bytes_remaining       = (bl_d != '0);
    result_o.fetch_request         = req;
    result_o.fetch_request_address = req_addr;
    result_o.fetch_from_output     = from_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= '0;
      sr_q     <= '0;
      br_q     <= dmc_pkg::BitsPerByte;
      silent_q <= 1'b1;
      buf_q    <= '0;
      empty_q  <= 1'b1;
      addr_q   <= '0;
      bl_q     <= '0;
      irq_q    <= 1'b0;
      div_q    <= '0;
    end else begin
      level_q  <= level_d;
      sr_q     <= sr_d;
      br_q     <= br_d;
      silent_q <= silent_d;
      buf_q    <= buf_d;
      empty_q  <= empty_d;
      addr_q   <= addr_d;
      bl_q     <= bl_d;
      irq_q    <= irq_d;
      div_q    <= div_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_en_q    <= 1'b0;
      loop_q      <= 1'b0;
      reload_q    <= '0;
      addr_code_q <= '0;
      len_code_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_i.index)
        dmc_pkg::REG_IRQ_EN: irq_en_q    <= cfg_i.value[0];
        dmc_pkg::REG_LOOP:   loop_q      <= cfg_i.value[0];
        dmc_pkg::REG_RATE:   reload_q    <= dmc_pkg::rate_reload(cfg_i.value[3:0]);
        dmc_pkg::REG_ADDR:   addr_code_q <= cfg_i.value;
        dmc_pkg::REG_LEN:    len_code_q  <= cfg_i.value;
        default: ;
      endcase
    end
  end

  // remaining bytes always point into the upper half of the address space
  a_addr_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bl_q != '0 |-> addr_q[15])
    else $error("bytes remain at an address below the sample area");

  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    br_q != '0 && br_q <= dmc_pkg::BitsPerByte)
    else $error("bit counter out of range");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(level_q) && $stable(bl_q) && $stable(div_q))
    else $error("channel state moved without an item");

endmodule

/* verif/tb_delta_modulation_sample_channel.sv */
// Self-checking testbench of the delta-modulation sample channel: random items vs. a local model.
module tb_delta_modulation_sample_channel;

  // Commands and register indexes outside the defined lists
  localparam logic [2:0] CmdUnusedLo = 3'd5;
  localparam logic [2:0] CmdUnusedHi = 3'd7;
  localparam logic [2:0] RegUnused   = 3'd7;

  // Output bit periods in clock ticks, rate index 15 in the top byte
  localparam logic [127:0] BitPeriods = {
    8'd27, 8'd36, 8'd42, 8'd53, 8'd64, 8'd71, 8'd80, 8'd95,
    8'd107, 8'd113, 8'd127, 8'd143, 8'd160, 8'd170, 8'd190, 8'd214
  };

  // Cycles without any handshake before the run is declared hung
  localparam int StallLimit = 2000;

  typedef enum logic [1:0] {
    TAKE_ALL,
    TAKE_HALF,
    TAKE_FEW
  } take_mode_e;

  // Full channel state plus its configuration
  typedef struct packed {
    logic        irq_en;
    logic        loop_on;
    logic [7:0]  addr_code;
    logic [7:0]  len_code;
    logic [7:0]  div_reload;
    logic [7:0]  div_count;
    logic [6:0]  level;
    logic [7:0]  shift_reg;
    logic [3:0]  bits_left;
    logic        silent;
    logic [7:0]  buffer;
    logic        buf_empty;
    logic [15:0] addr;
    logic [11:0] bytes_left;
    logic        irq;
  } chan_state_t;

  logic clk_i;
  logic rst_ni;

  dmc_stream_if #(.T(dmc_pkg::in_item_t))  in_if ();
  dmc_stream_if #(.T(dmc_pkg::cfg_item_t)) cfg_if ();
  dmc_stream_if #(.T(dmc_pkg::out_item_t)) out_if ();

  delta_modulation_sample_channel dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  chan_state_t        chan_model;   // advanced on every accepted item
  chan_state_t        stim_chan;    // advanced as items are queued, steers the stimulus
  dmc_pkg::in_item_t  queued_items[$];
  dmc_pkg::out_item_t pending_outputs[$];
  int          errors = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          idle_cycles = 0;
  take_mode_e  take_mode = TAKE_ALL;
  int          take_run = 0;

  function automatic chan_state_t chan_after_reset();
    chan_state_t s;
    s = '0;
    s.bits_left = dmc_pkg::BitsPerByte;
    s.silent    = 1'b1;
    s.buf_empty = 1'b1;
    return s;
  endfunction

  function automatic void chan_write_reg(inout chan_state_t s, input dmc_pkg::cfg_item_t w);
    case (w.index)
      dmc_pkg::REG_IRQ_EN: begin
        s.irq_en = w.value[0];
        if (!w.value[0]) s.irq = 1'b0;
      end
      dmc_pkg::REG_LOOP: s.loop_on = w.value[0];
      dmc_pkg::REG_RATE: s.div_reload = BitPeriods[w.value[3:0]*8 +: 8] - 8'd1;
      dmc_pkg::REG_ADDR: s.addr_code = w.value;
      dmc_pkg::REG_LEN:  s.len_code = w.value;
      default: ;
    endcase
  endfunction

  function automatic void chan_restart(inout chan_state_t s);
    s.addr       = dmc_pkg::AddrBase + {2'b00, s.addr_code, 6'b000000};
    s.bytes_left = {s.len_code, 4'b0000} + 12'd1;
  endfunction

  // Advance the channel by one item and return the output it shows
  function automatic void channel_step(inout chan_state_t s, input dmc_pkg::in_item_t it,
                                       output dmc_pkg::out_item_t r);
    r = '0;
    case (it.command)
      dmc_pkg::CMD_TICK: begin
        if (s.div_count == 8'd0) begin
          s.div_count = s.div_reload;
          // divider fires: step the level, then shift one bit out
          if (!s.silent) begin
            if (s.shift_reg[0]) begin
              if ({1'b0, s.level} + {1'b0, dmc_pkg::LevelStep} <= {1'b0, dmc_pkg::LevelMax})
                s.level = s.level + dmc_pkg::LevelStep;
            end else if (s.level >= dmc_pkg::LevelStep) begin
              s.level = s.level - dmc_pkg::LevelStep;
            end
          end
          s.shift_reg = s.shift_reg >> 1;
          s.bits_left = s.bits_left - 4'd1;
          if (s.bits_left == 4'd0) begin
            s.bits_left = dmc_pkg::BitsPerByte;
            if (s.buf_empty) begin
              s.silent = 1'b1;
            end else begin
              s.silent    = 1'b0;
              s.shift_reg = s.buffer;
              s.buf_empty = 1'b1;
              if (s.bytes_left != 12'd0) begin
                r.fetch_request         = 1'b1;
                r.fetch_from_output     = 1'b1;
                r.fetch_request_address = s.addr;
              end
            end
          end
        end else begin
          s.div_count = s.div_count - 8'd1;
        end
      end
      dmc_pkg::CMD_FETCH: begin
        if (it.fetch_address == s.addr && s.bytes_left != 12'd0) begin
          s.buffer    = it.data_value;
          s.buf_empty = 1'b0;
          s.addr      = (s.addr == dmc_pkg::AddrTop) ? dmc_pkg::AddrWrap : s.addr + 16'd1;
          s.bytes_left = s.bytes_left - 12'd1;
          if (s.bytes_left == 12'd0) begin
            if (s.loop_on) chan_restart(s);
            else if (s.irq_en) s.irq = 1'b1;
          end
        end
      end
      dmc_pkg::CMD_ENABLE: begin
        if (!it.enable_flag) begin
          s.bytes_left = '0;
        end else if (s.bytes_left == 12'd0) begin
          chan_restart(s);
          if (s.buf_empty) begin
            r.fetch_request         = 1'b1;
            r.fetch_request_address = s.addr;
          end
        end
      end
      dmc_pkg::CMD_LOAD:    s.level = it.data_value[6:0];
      dmc_pkg::CMD_CLR_IRQ: s.irq = 1'b0;
      default: ;
    endcase
    r.output_level    = s.level;
    r.irq_pending     = s.irq;
    r.bytes_remaining = (s.bytes_left != 12'd0);
  endfunction

  // Pick a random item; fetches mostly carry the address the channel waits for
  function automatic dmc_pkg::in_item_t pick_item(input chan_state_t g, input int fetch_pct);
    dmc_pkg::in_item_t it;
    int roll;
    it   = dmc_pkg::in_item_t'($urandom);
    roll = $urandom_range(99);
    if (roll < fetch_pct) begin
      it.command = dmc_pkg::CMD_FETCH;
      if (g.bytes_left != 12'd0 && $urandom_range(9) != 0) it.fetch_address = g.addr;
    end else if (roll < fetch_pct + 4) begin
      it.command     = dmc_pkg::CMD_ENABLE;
      it.enable_flag = ($urandom_range(4) != 0);
    end else if (roll < fetch_pct + 8) begin
      it.command = dmc_pkg::CMD_LOAD;
    end else if (roll < fetch_pct + 10) begin
      it.command = dmc_pkg::CMD_CLR_IRQ;
    end else if (roll < fetch_pct + 12) begin
      it.command = 3'($urandom_range(CmdUnusedHi, CmdUnusedLo));
    end else begin
      it.command = dmc_pkg::CMD_TICK;
    end
    return it;
  endfunction

  task automatic add_item(input logic [2:0] cmd, input logic en, input logic [7:0] data,
                          input logic [15:0] faddr);
    dmc_pkg::in_item_t  it;
    dmc_pkg::out_item_t ignored;
    it = {cmd, en, data, faddr};
    channel_step(stim_chan, it, ignored);
    queued_items.push_back(it);
  endtask

  // Drive one register write; valid stays high until the caller drops it
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    dmc_pkg::cfg_item_t w;
    w = {idx, value};
    chan_write_reg(stim_chan, w);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    @(posedge clk_i);
    while (!(cfg_if.valid && cfg_if.ready)) @(posedge clk_i);
  endtask

  // Hold until every queued item went in and every output came back;
  // look at the falling edge, after the driver and monitor have settled
  task automatic wait_idle();
    @(negedge clk_i);
    while (queued_items.size() != 0 || in_if.valid || pending_outputs.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Drain, reconfigure, then queue a batch of random items; rate < 0 keeps the rate
  task automatic run_phase(input logic irq_en, input logic loop_on, input int rate,
                           input logic [7:0] addr_code, input logic [7:0] len_code,
                           input int n, input int fetch_pct);
    dmc_pkg::in_item_t it;
    wait_idle();
    write_reg(dmc_pkg::REG_IRQ_EN, {7'($urandom), irq_en});
    write_reg(dmc_pkg::REG_LOOP, {7'($urandom), loop_on});
    if (rate >= 0) write_reg(dmc_pkg::REG_RATE, {4'($urandom), 4'(rate)});
    write_reg(dmc_pkg::REG_ADDR, addr_code);
    write_reg(dmc_pkg::REG_LEN, len_code);
    write_reg(RegUnused, 8'($urandom));
    cfg_if.valid <= 1'b0;
    for (int k = 0; k < n; k++) begin
      it = pick_item(stim_chan, fetch_pct);
      add_item(it.command, it.enable_flag, it.data_value, it.fetch_address);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    out_if.ready = 1'b0;
    chan_model   = chan_after_reset();
    stim_chan    = chan_after_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: divider still reloads with zero, so every tick moves one bit.
    // One-byte sample at the top start address, interrupt armed.
    run_phase(1'b1, 1'b0, -1, 8'hFF, 8'h00, 0, 0);
    add_item(CmdUnusedHi, 1'b1, 8'hFF, 16'hFFFF);   // unknown commands change nothing
    add_item(CmdUnusedLo, 1'b0, 8'h00, 16'h0000);
    add_item(dmc_pkg::CMD_LOAD, 1'b0, 8'hFF, 16'h0000);      // level to the top, bit 7 dropped
    add_item(dmc_pkg::CMD_LOAD, 1'b1, 8'h80, 16'hFFFF);      // level to zero
    add_item(dmc_pkg::CMD_ENABLE, 1'b1, 8'h00, 16'h0000);    // fetch asked by enable
    add_item(dmc_pkg::CMD_FETCH, 1'b0, 8'hAA, 16'h0000);     // wrong address: drop
    add_item(dmc_pkg::CMD_FETCH, 1'b0, 8'hFF, 16'hFFC0);     // last byte: interrupt
    add_item(dmc_pkg::CMD_FETCH, 1'b0, 8'h00, 16'hFFC1);     // nothing left: drop
    add_item(dmc_pkg::CMD_CLR_IRQ, 1'b0, 8'h00, 16'h0000);
    add_item(dmc_pkg::CMD_LOAD, 1'b0, 8'h7D, 16'h0000);
    // eight ticks move the buffer into the shift register, then its ones push the level into the ceiling
    for (int k = 0; k < 12; k++) add_item(dmc_pkg::CMD_TICK, 1'b0, 8'h00, 16'h0000);
    add_item(dmc_pkg::CMD_ENABLE, 1'b1, 8'h00, 16'h0000);
    add_item(dmc_pkg::CMD_ENABLE, 1'b0, 8'h00, 16'h0000);
    add_item(dmc_pkg::CMD_TICK, 1'b0, 8'h00, 16'h0000);

    // Random phases at the fastest divider; the first one wraps past the top
    run_phase(1'b1, 1'b0, -1, 8'hFF, 8'h04, 220, 40);
    run_phase(1'b0, 1'b1, -1, 8'h00, 8'h00, 150, 20);
    run_phase(1'b1, 1'b1, -1, 8'($urandom), 8'hFF, 150, 25);
    run_phase(1'b1, 1'b0, -1, 8'($urandom), 8'($urandom_range(3)), 150, 20);
    // Rate extremes, then random settings
    run_phase(1'b1, 1'b0, 15, 8'($urandom), 8'h01, 250, 5);
    run_phase(1'b0, 1'b1, 0, 8'($urandom), 8'h00, 100, 10);
    for (int p = 0; p < 4; p++)
      run_phase(1'($urandom), 1'($urandom), $urandom_range(15), 8'($urandom),
                8'($urandom_range(3)), 75, $urandom_range(30, 5));
    wait_idle();

    if (errors == 0) begin
      $display("tb_delta_modulation_sample_channel: done, clean");
    end else begin
      $display("tb_delta_modulation_sample_channel: done, errors");
    end
    $finish;
  end

  // Sender: bursts of random length with random gaps; hold an item until taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && !in_if.ready) begin
        // hold the current item
      end else if (gap_left != 0) begin
        in_if.valid <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (queued_items.size() != 0) begin
        in_if.valid <= 1'b1;
        in_if.data  <= queued_items.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left   <= ($urandom_range(3) == 0) ? $urandom_range(25) : $urandom_range(2);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: switch between always ready, half ready and mostly stalled
  always @(posedge clk_i) begin
    if (take_run == 0) begin
      take_mode <= take_mode_e'($urandom_range(2));
      take_run  <= $urandom_range(150, 20);
    end else begin
      take_run <= take_run - 1;
    end
    case (take_mode)
      TAKE_ALL:  out_if.ready <= 1'b1;
      TAKE_HALF: out_if.ready <= 1'($urandom_range(1));
      default:   out_if.ready <= ($urandom_range(3) == 0);
    endcase
  end

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // Check outputs against the oldest expectation, then record new items
  always @(posedge clk_i) begin : result_check
    dmc_pkg::out_item_t want;
    dmc_pkg::out_item_t got;
    dmc_pkg::out_item_t next;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (pending_outputs.size() == 0) begin
          errors++;
          $display("%0t: output expected none, got %h", $time, got);
        end else begin
          want = pending_outputs.pop_front();
          check_field("output_level", want.output_level, got.output_level);
          check_field("irq_pending", want.irq_pending, got.irq_pending);
          check_field("bytes_remaining", want.bytes_remaining, got.bytes_remaining);
          check_field("fetch_request", want.fetch_request, got.fetch_request);
          check_field("fetch_request_address", want.fetch_request_address,
                      got.fetch_request_address);
          check_field("fetch_from_output", want.fetch_from_output, got.fetch_from_output);
        end
      end
      if (cfg_if.valid && cfg_if.ready) chan_write_reg(chan_model, cfg_if.data);
      if (in_if.valid && in_if.ready) begin
        channel_step(chan_model, in_if.data, next);
        pending_outputs.push_back(next);
      end
    end
  end

  // Watchdog: end a run in which nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("tb_delta_modulation_sample_channel: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
